@@ src/gap_pkg.sv @@
// Shared types and constants for the grid A* path planner.
// No dependencies; used by gap_open and grid_astar_path_planner_top.
package gap_pkg;

    // command codes on the input transfer
    typedef enum logic [1:0] {
        MODE_LOAD = 2'd0,
        MODE_PLAN = 2'd1,
        MODE_READ = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        KIND_FREE  = 2'd0,
        KIND_WALL  = 2'd1,
        KIND_ROBOT = 2'd2
    } kind_t;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_GOAL_WALL = 3'd1;
    localparam logic [2:0] ST_OUTSIDE   = 3'd2;
    localparam logic [2:0] ST_NO_PATH   = 3'd3;
    localparam logic [2:0] ST_BAD_INDEX = 3'd4;

    localparam logic CFG_MAP_WIDTH  = 1'b0;
    localparam logic CFG_MAP_HEIGHT = 1'b1;
    localparam logic [5:0] MAP_SIZE_RESET = 6'd32;

    // search mark width; a sweep restores marks when it wraps
    localparam int EPOCH_W = 4;

    typedef enum logic [1:0] {
        NODE_NONE   = 2'd0,
        NODE_OPEN   = 2'd1,
        NODE_CLOSED = 2'd2
    } node_state_t;

    // neighbor order: west, east, north, south
    typedef enum logic [1:0] {
        DIR_W = 2'd0,
        DIR_E = 2'd1,
        DIR_N = 2'd2,
        DIR_S = 2'd3
    } dir_t;

    typedef enum logic [2:0] {
        OP_CLEAR  = 3'd0,
        OP_MIN    = 3'd1,
        OP_REMOVE = 3'd2,
        OP_INSERT = 3'd3,
        OP_UPDATE = 3'd4
    } open_op_t;

    typedef struct packed {
        logic     valid;
        open_op_t op;
    } open_req_t;

    typedef struct packed {
        logic done;
        logic empty;
    } open_rsp_t;

    typedef enum logic [2:0] {
        OS_IDLE,
        OS_MIN,
        OS_FIND,
        OS_REMOVE,
        OS_ACK
    } open_state_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_GOAL,
        S_SCRUB,
        S_INIT,
        S_START_CLOSE,
        S_NB,
        S_NB_CHECK,
        S_NB_WAIT,
        S_NEXT,
        S_MIN_WAIT,
        S_REMOVE,
        S_REM_WAIT,
        S_PATH,
        S_PATH_RD,
        S_PATH_CHECK
    } ctrl_state_t;

endpackage

@@ src/gap_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module gap_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/gap_open.sv @@
// Open list unit: entries in a RAM, sequential min scan, lookup by cell,
// append and swap-remove. Depends on gap_pkg and gap_ram.
module gap_open #(
    parameter int CB       = 10,
    parameter int CNTW     = 11,
    parameter int CAPACITY = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  gap_pkg::open_req_t  req,
    input  logic [CB-1:0]       key_cell,
    input  logic [CB-1:0]       key_parent,
    input  logic [CNTW-1:0]     key_g,
    input  logic [CNTW:0]       key_f,
    output gap_pkg::open_rsp_t  rsp,
    output logic [CB-1:0]       best_cell,
    output logic [CB-1:0]       best_parent,
    output logic [CNTW-1:0]     best_g
);

    localparam int EW = 2 * CB + 2 * CNTW + 1;
    localparam int DEPTH = 1 << CB;

    gap_pkg::open_state_t state_reg, state_next;
    logic [CNTW-1:0] count_reg, count_next;
    logic [CNTW-1:0] scan_reg, scan_next;
    logic            pend_reg, pend_next;
    logic [CNTW-1:0] pend_idx_reg, pend_idx_next;
    logic [EW-1:0]   best_reg, best_next;
    logic [CNTW-1:0] best_idx_reg, best_idx_next;
    logic [EW-1:0]   key_reg, key_next;

    logic            we;
    logic [CB-1:0]   waddr, raddr;
    logic [EW-1:0]   wdata, rdata;
    logic [CNTW-1:0] count_m1;
    logic [CB-1:0]   rd_cell;
    logic [CNTW:0]   rd_f;

    gap_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_open_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // entry layout {cell, parent, g, f}
    assign rd_cell  = rdata[EW-1 -: CB];
    assign rd_f     = rdata[CNTW:0];
    assign count_m1 = count_reg - 1'b1;

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        scan_next     = scan_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        best_next     = best_reg;
        best_idx_next = best_idx_reg;
        key_next      = key_reg;
        we            = 1'b0;
        waddr         = count_reg[CB-1:0];
        wdata         = key_reg;
        raddr         = scan_reg[CB-1:0];
        rsp.done      = 1'b0;
        rsp.empty     = (count_reg == '0);

        unique case (state_reg)
            gap_pkg::OS_IDLE:
            begin
                if (req.valid)
                begin
                    case (req.op)
                        gap_pkg::OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        gap_pkg::OP_MIN:
                        begin
                            scan_next  = '0;
                            pend_next  = 1'b0;
                            state_next = gap_pkg::OS_MIN;
                        end
                        gap_pkg::OP_UPDATE:
                        begin
                            key_next   = {key_cell, key_parent, key_g, key_f};
                            scan_next  = '0;
                            pend_next  = 1'b0;
                            state_next = gap_pkg::OS_FIND;
                        end
                        gap_pkg::OP_INSERT:
                        begin
                            if (count_reg < CNTW'(CAPACITY))
                            begin
                                we         = 1'b1;
                                wdata      = {key_cell, key_parent, key_g, key_f};
                                count_next = count_reg + 1'b1;
                            end
                            state_next = gap_pkg::OS_ACK;
                        end
                        gap_pkg::OP_REMOVE:
                        begin
                            raddr      = count_m1[CB-1:0];
                            state_next = gap_pkg::OS_REMOVE;
                        end
                        default:
                        begin
                            state_next = gap_pkg::OS_IDLE;
                        end
                    endcase
                end
            end
            gap_pkg::OS_MIN:
            begin
                if (scan_reg < count_reg)
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = scan_reg;
                    scan_next     = scan_reg + 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                // first entry of least f wins
                if (pend_reg && (pend_idx_reg == '0 || rd_f < best_reg[CNTW:0]))
                begin
                    best_next     = rdata;
                    best_idx_next = pend_idx_reg;
                end
                if (!pend_reg && scan_reg == count_reg)
                begin
                    rsp.done   = 1'b1;
                    state_next = gap_pkg::OS_IDLE;
                end
            end
            gap_pkg::OS_FIND:
            begin
                if (scan_reg < count_reg)
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = scan_reg;
                    scan_next     = scan_reg + 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg && rd_cell == key_reg[EW-1 -: CB])
                begin
                    if (key_reg[CNTW:0] < rd_f)
                    begin
                        we    = 1'b1;
                        waddr = pend_idx_reg[CB-1:0];
                    end
                    rsp.done   = 1'b1;
                    state_next = gap_pkg::OS_IDLE;
                end
                else if (!pend_reg && scan_reg == count_reg)
                begin
                    rsp.done   = 1'b1;
                    state_next = gap_pkg::OS_IDLE;
                end
            end
            gap_pkg::OS_REMOVE:
            begin
                // last entry moves into the freed slot
                we         = 1'b1;
                waddr      = best_idx_reg[CB-1:0];
                wdata      = rdata;
                count_next = count_m1;
                rsp.done   = 1'b1;
                state_next = gap_pkg::OS_IDLE;
            end
            gap_pkg::OS_ACK:
            begin
                rsp.done   = 1'b1;
                state_next = gap_pkg::OS_IDLE;
            end
            default:
            begin
                state_next = gap_pkg::OS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gap_pkg::OS_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg     <= scan_next;
        pend_idx_reg <= pend_idx_next;
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
        key_reg      <= key_next;
    end

    assign best_cell   = best_reg[EW-1 -: CB];
    assign best_parent = best_reg[EW-CB-1 -: CB];
    assign best_g      = best_reg[CNTW+1 +: CNTW];

endmodule

@@ src/grid_astar_path_planner_top.sv @@
// Top level of the grid A* path planner: command sequencer, cell and path RAMs.
// Depends on gap_pkg, gap_ram and gap_open.
//
// A* search on a 4-connected grid, Manhattan heuristic, unit step cost.
// A command transfer is taken when start is high and busy is low; exactly
// one result follows, on status/path_length/point_x/point_y for the single
// cycle in which done is high. The receiver cannot stall: sample the result
// on that cycle. Loads (mode 0) and commands rejected at the transfer answer
// in the cycle after it, path reads (mode 2) after the path RAM read and the
// S_READ state. A plan (mode 1) runs a sequencer around the cell RAM (wall
// bit, search mark, node state, parent per cell) and the open list unit: each
// expansion makes one pass over the open list to find the least f, checks
// each neighbor in turn and makes one more open list pass for each neighbor
// that is already open; the path walk back reads the cell RAM once per point.
// Each cell carries a 4-bit search mark; a plan that passes the goal checks
// with the mark at 15 first sweeps the cell RAM to restore the marks. After
// reset the block clears the cell RAM, one cell per cycle (2^CB cells, 1024
// at the default size), with busy high; configuration writes are taken at
// any time.
module grid_astar_path_planner_top #(
    parameter int MAX_WIDTH  = 32,
    parameter int MAX_HEIGHT = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [5:0]  cfg_wdata,
    input  logic [1:0]  mode,
    input  logic [5:0]  pos_x,
    input  logic [5:0]  pos_y,
    input  logic [1:0]  cell_kind,
    input  logic [9:0]  step_index,
    output logic        done,
    output logic [2:0]  status,
    output logic [10:0] path_length,
    output logic [4:0]  point_x,
    output logic [4:0]  point_y
);

    localparam int XB     = $clog2(MAX_WIDTH);
    localparam int YB     = $clog2(MAX_HEIGHT);
    localparam int CB     = XB + YB;                  // cell index {y, x}
    localparam int CELLS  = MAX_WIDTH * MAX_HEIGHT;
    localparam int CDEPTH = 1 << CB;
    localparam int CNTW   = CB + 1;
    localparam int EPW    = gap_pkg::EPOCH_W;
    localparam int CW     = 1 + EPW + 2 + CB;         // {wall, mark, state, parent}
    localparam int IW     = (CNTW > 10) ? CNTW : 10;

    gap_pkg::ctrl_state_t state_reg, state_next;

    logic [5:0]      w_reg, h_reg;
    logic [XB-1:0]   robot_x_reg, robot_x_next;
    logic [YB-1:0]   robot_y_reg, robot_y_next;
    logic [EPW-1:0]  epoch_reg, epoch_next;
    logic [CB:0]     sweep_reg, sweep_next;
    logic [XB-1:0]   goal_x_reg, goal_x_next;
    logic [YB-1:0]   goal_y_reg, goal_y_next;
    logic [CB-1:0]   start_cell_reg, start_cell_next;
    logic [CB-1:0]   cur_cell_reg, cur_cell_next;
    logic [CNTW-1:0] cur_g_reg, cur_g_next;
    gap_pkg::dir_t   dir_reg, dir_next;
    logic [CB-1:0]   nb_cell_reg, nb_cell_next;
    logic [CNTW-1:0] nb_g_reg, nb_g_next;
    logic [CNTW:0]   nb_f_reg, nb_f_next;
    logic [CNTW-1:0] len_reg, len_next;
    logic [CB-1:0]   pcur_reg, pcur_next;
    logic [CNTW-1:0] stored_len_reg, stored_len_next;

    logic            done_reg;
    logic [2:0]      status_reg;
    logic [4:0]      point_x_reg, point_y_reg;
    logic            out_set;
    logic [2:0]      out_status;
    logic [4:0]      out_px, out_py;

    // cell RAM
    logic            cell_we;
    logic [CB-1:0]   cell_waddr, cell_raddr;
    logic [CW-1:0]   cell_wdata, cell_rdata;
    logic            rd_wall;
    logic [EPW-1:0]  rd_epoch;
    logic [1:0]      rd_ns;
    logic [CB-1:0]   rd_parent;
    logic            rd_mark_ok;

    // path RAM
    logic            path_we;
    logic [CB-1:0]   path_waddr, path_raddr;
    logic [CB-1:0]   path_wdata, path_rdata;

    // open list unit
    gap_pkg::open_req_t open_req;
    gap_pkg::open_rsp_t open_rsp;
    logic [CB-1:0]   best_cell, best_parent;
    logic [CNTW-1:0] best_g;

    logic [6:0]      eff_w, eff_h;
    logic            pos_out;
    logic [CB-1:0]   pos_cell;
    logic [XB-1:0]   cur_x, nb_x;
    logic [YB-1:0]   cur_y, nb_y;
    logic            nb_ok;
    logic [XB-1:0]   dx;
    logic [YB-1:0]   dy;
    logic [CB-1:0]   goal_cell;
    logic            is_open;

    gap_ram #(.WIDTH(CW), .DEPTH(CDEPTH)) u_cell_ram (
        .clk   (clk),
        .we    (cell_we),
        .waddr (cell_waddr),
        .wdata (cell_wdata),
        .raddr (cell_raddr),
        .rdata (cell_rdata)
    );

    gap_ram #(.WIDTH(CB), .DEPTH(CDEPTH)) u_path_ram (
        .clk   (clk),
        .we    (path_we),
        .waddr (path_waddr),
        .wdata (path_wdata),
        .raddr (path_raddr),
        .rdata (path_rdata)
    );

    gap_open #(.CB(CB), .CNTW(CNTW), .CAPACITY(CELLS)) u_open (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (open_req),
        .key_cell    (nb_cell_reg),
        .key_parent  (cur_cell_reg),
        .key_g       (nb_g_reg),
        .key_f       (nb_f_reg),
        .rsp         (open_rsp),
        .best_cell   (best_cell),
        .best_parent (best_parent),
        .best_g      (best_g)
    );

    // register values above the build size act as the build size
    assign eff_w = ({1'b0, w_reg} < 7'(MAX_WIDTH))  ? {1'b0, w_reg} : 7'(MAX_WIDTH);
    assign eff_h = ({1'b0, h_reg} < 7'(MAX_HEIGHT)) ? {1'b0, h_reg} : 7'(MAX_HEIGHT);

    assign pos_out  = ({1'b0, pos_x} >= eff_w) || ({1'b0, pos_y} >= eff_h);
    assign pos_cell = {pos_y[YB-1:0], pos_x[XB-1:0]};
    assign goal_cell = {goal_y_reg, goal_x_reg};

    assign rd_wall    = cell_rdata[CW-1];
    assign rd_epoch   = cell_rdata[CW-2 -: EPW];
    assign rd_ns      = cell_rdata[CB+1:CB];
    assign rd_parent  = cell_rdata[CB-1:0];
    assign rd_mark_ok = (rd_epoch == epoch_reg);

    assign cur_x = cur_cell_reg[XB-1:0];
    assign cur_y = cur_cell_reg[CB-1:XB];

    // neighbor of the current cell; off-grid neighbors are blocked
    always_comb
    begin
        nb_x  = cur_x;
        nb_y  = cur_y;
        nb_ok = 1'b0;
        unique case (dir_reg)
            gap_pkg::DIR_W:
            begin
                nb_ok = (cur_x != '0);
                nb_x  = cur_x - 1'b1;
            end
            gap_pkg::DIR_E:
            begin
                nb_ok = (7'(cur_x) + 7'd1 < eff_w);
                nb_x  = cur_x + 1'b1;
            end
            gap_pkg::DIR_N:
            begin
                nb_ok = (cur_y != '0);
                nb_y  = cur_y - 1'b1;
            end
            gap_pkg::DIR_S:
            begin
                nb_ok = (7'(cur_y) + 7'd1 < eff_h);
                nb_y  = cur_y + 1'b1;
            end
            default:
            begin
                nb_ok = 1'b0;
            end
        endcase
    end

    assign dx = (nb_x > goal_x_reg) ? nb_x - goal_x_reg : goal_x_reg - nb_x;
    assign dy = (nb_y > goal_y_reg) ? nb_y - goal_y_reg : goal_y_reg - nb_y;
    assign is_open = rd_mark_ok && (rd_ns == gap_pkg::NODE_OPEN);

    always_comb
    begin
        state_next      = state_reg;
        robot_x_next    = robot_x_reg;
        robot_y_next    = robot_y_reg;
        epoch_next      = epoch_reg;
        sweep_next      = sweep_reg;
        goal_x_next     = goal_x_reg;
        goal_y_next     = goal_y_reg;
        start_cell_next = start_cell_reg;
        cur_cell_next   = cur_cell_reg;
        cur_g_next      = cur_g_reg;
        dir_next        = dir_reg;
        nb_cell_next    = nb_cell_reg;
        nb_g_next       = nb_g_reg;
        nb_f_next       = nb_f_reg;
        len_next        = len_reg;
        pcur_next       = pcur_reg;
        stored_len_next = stored_len_reg;
        out_set         = 1'b0;
        out_status      = gap_pkg::ST_OK;
        out_px          = '0;
        out_py          = '0;
        cell_we         = 1'b0;
        cell_waddr      = '0;
        cell_wdata      = '0;
        cell_raddr      = '0;
        path_we         = 1'b0;
        path_waddr      = '0;
        path_wdata      = '0;
        path_raddr      = '0;
        open_req.valid  = 1'b0;
        open_req.op     = gap_pkg::OP_CLEAR;

        unique case (state_reg)
            gap_pkg::S_CLEAR:
            begin
                // all cells free after reset
                cell_we    = 1'b1;
                cell_waddr = sweep_reg[CB-1:0];
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == (CB+1)'(CDEPTH - 1))
                begin
                    state_next = gap_pkg::S_IDLE;
                end
            end
            gap_pkg::S_IDLE:
            begin
                if (start)
                begin
                    unique case (gap_pkg::mode_t'(mode))
                        gap_pkg::MODE_LOAD:
                        begin
                            out_set = 1'b1;
                            if (pos_out)
                            begin
                                out_status = gap_pkg::ST_OUTSIDE;
                            end
                            else
                            begin
                                // a load leaves a zero mark: not part of any search
                                cell_waddr = pos_cell;
                                case (gap_pkg::kind_t'(cell_kind))
                                    gap_pkg::KIND_FREE:
                                    begin
                                        cell_we = 1'b1;
                                    end
                                    gap_pkg::KIND_WALL:
                                    begin
                                        cell_we    = 1'b1;
                                        cell_wdata = {1'b1, (CW-1)'(0)};
                                    end
                                    gap_pkg::KIND_ROBOT:
                                    begin
                                        cell_we      = 1'b1;
                                        robot_x_next = pos_x[XB-1:0];
                                        robot_y_next = pos_y[YB-1:0];
                                    end
                                    default:
                                    begin
                                        cell_we = 1'b0;
                                    end
                                endcase
                            end
                        end
                        gap_pkg::MODE_PLAN:
                        begin
                            if (pos_out)
                            begin
                                out_set    = 1'b1;
                                out_status = gap_pkg::ST_OUTSIDE;
                            end
                            else
                            begin
                                goal_x_next = pos_x[XB-1:0];
                                goal_y_next = pos_y[YB-1:0];
                                cell_raddr  = pos_cell;
                                state_next  = gap_pkg::S_GOAL;
                            end
                        end
                        gap_pkg::MODE_READ:
                        begin
                            if (IW'(step_index) < IW'(stored_len_reg))
                            begin
                                path_raddr = CB'(step_index);
                                state_next = gap_pkg::S_READ;
                            end
                            else
                            begin
                                out_set    = 1'b1;
                                out_status = gap_pkg::ST_BAD_INDEX;
                            end
                        end
                        default:
                        begin
                            out_set    = 1'b1;
                            out_status = gap_pkg::ST_BAD_INDEX;
                        end
                    endcase
                end
            end
            gap_pkg::S_READ:
            begin
                out_set    = 1'b1;
                out_px     = 5'(path_rdata[XB-1:0]);
                out_py     = 5'(path_rdata[CB-1:XB]);
                state_next = gap_pkg::S_IDLE;
            end
            gap_pkg::S_GOAL:
            begin
                if (rd_wall)
                begin
                    out_set    = 1'b1;
                    out_status = gap_pkg::ST_GOAL_WALL;
                    state_next = gap_pkg::S_IDLE;
                end
                else if (7'(robot_x_reg) >= eff_w || 7'(robot_y_reg) >= eff_h)
                begin
                    out_set    = 1'b1;
                    out_status = gap_pkg::ST_NO_PATH;
                    state_next = gap_pkg::S_IDLE;
                end
                else if (epoch_reg == {EPW{1'b1}})
                begin
                    sweep_next = '0;
                    state_next = gap_pkg::S_SCRUB;
                end
                else
                begin
                    state_next = gap_pkg::S_INIT;
                end
            end
            gap_pkg::S_SCRUB:
            begin
                // read cell i, write cell i-1 back with its wall bit and a zero mark
                cell_raddr = sweep_reg[CB-1:0];
                if (sweep_reg != '0)
                begin
                    cell_we    = 1'b1;
                    cell_waddr = CB'(sweep_reg - 1'b1);
                    cell_wdata = {rd_wall, (CW-1)'(0)};
                end
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == (CB+1)'(CDEPTH))
                begin
                    epoch_next = '0;
                    state_next = gap_pkg::S_INIT;
                end
            end
            gap_pkg::S_INIT:
            begin
                epoch_next      = epoch_reg + 1'b1;
                start_cell_next = {robot_y_reg, robot_x_reg};
                cur_cell_next   = {robot_y_reg, robot_x_reg};
                cur_g_next      = '0;
                cell_raddr      = {robot_y_reg, robot_x_reg};
                open_req.valid  = 1'b1;
                open_req.op     = gap_pkg::OP_CLEAR;
                state_next      = gap_pkg::S_START_CLOSE;
            end
            gap_pkg::S_START_CLOSE:
            begin
                // start keeps its wall bit: the search never tests it
                cell_we    = 1'b1;
                cell_waddr = start_cell_reg;
                cell_wdata = {rd_wall, epoch_reg, gap_pkg::NODE_CLOSED, start_cell_reg};
                dir_next   = gap_pkg::DIR_W;
                state_next = gap_pkg::S_NB;
            end
            gap_pkg::S_NB:
            begin
                if (nb_ok)
                begin
                    nb_cell_next = {nb_y, nb_x};
                    nb_g_next    = cur_g_reg + 1'b1;
                    nb_f_next    = (CNTW+1)'(cur_g_reg) + 1'b1
                                 + (CNTW+1)'(dx) + (CNTW+1)'(dy);
                    cell_raddr   = {nb_y, nb_x};
                    state_next   = gap_pkg::S_NB_CHECK;
                end
                else if (dir_reg == gap_pkg::DIR_S)
                begin
                    state_next = gap_pkg::S_NEXT;
                end
                else
                begin
                    dir_next = gap_pkg::dir_t'(dir_reg + 1'b1);
                end
            end
            gap_pkg::S_NB_CHECK:
            begin
                if (rd_wall || (rd_mark_ok && rd_ns == gap_pkg::NODE_CLOSED))
                begin
                    if (dir_reg == gap_pkg::DIR_S)
                    begin
                        state_next = gap_pkg::S_NEXT;
                    end
                    else
                    begin
                        dir_next   = gap_pkg::dir_t'(dir_reg + 1'b1);
                        state_next = gap_pkg::S_NB;
                    end
                end
                else
                begin
                    open_req.valid = 1'b1;
                    open_req.op    = is_open ? gap_pkg::OP_UPDATE : gap_pkg::OP_INSERT;
                    if (!is_open)
                    begin
                        cell_we    = 1'b1;
                        cell_waddr = nb_cell_reg;
                        cell_wdata = {1'b0, epoch_reg, gap_pkg::NODE_OPEN, CB'(0)};
                    end
                    state_next = gap_pkg::S_NB_WAIT;
                end
            end
            gap_pkg::S_NB_WAIT:
            begin
                if (open_rsp.done)
                begin
                    if (dir_reg == gap_pkg::DIR_S)
                    begin
                        state_next = gap_pkg::S_NEXT;
                    end
                    else
                    begin
                        dir_next   = gap_pkg::dir_t'(dir_reg + 1'b1);
                        state_next = gap_pkg::S_NB;
                    end
                end
            end
            gap_pkg::S_NEXT:
            begin
                if (cur_cell_reg == goal_cell)
                begin
                    state_next = gap_pkg::S_PATH;
                end
                else if (open_rsp.empty)
                begin
                    out_set    = 1'b1;
                    out_status = gap_pkg::ST_NO_PATH;
                    state_next = gap_pkg::S_IDLE;
                end
                else
                begin
                    open_req.valid = 1'b1;
                    open_req.op    = gap_pkg::OP_MIN;
                    state_next     = gap_pkg::S_MIN_WAIT;
                end
            end
            gap_pkg::S_MIN_WAIT:
            begin
                if (open_rsp.done)
                begin
                    cur_cell_next = best_cell;
                    cur_g_next    = best_g;
                    cell_we       = 1'b1;
                    cell_waddr    = best_cell;
                    cell_wdata    = {1'b0, epoch_reg, gap_pkg::NODE_CLOSED, best_parent};
                    state_next    = gap_pkg::S_REMOVE;
                end
            end
            gap_pkg::S_REMOVE:
            begin
                // open list unit is back in idle here and takes the request
                open_req.valid = 1'b1;
                open_req.op    = gap_pkg::OP_REMOVE;
                state_next     = gap_pkg::S_REM_WAIT;
            end
            gap_pkg::S_REM_WAIT:
            begin
                if (open_rsp.done)
                begin
                    dir_next   = gap_pkg::DIR_W;
                    state_next = gap_pkg::S_NB;
                end
            end
            gap_pkg::S_PATH:
            begin
                path_we    = 1'b1;
                path_waddr = '0;
                path_wdata = goal_cell;
                len_next   = CNTW'(1);
                pcur_next  = goal_cell;
                state_next = gap_pkg::S_PATH_RD;
            end
            gap_pkg::S_PATH_RD:
            begin
                if (pcur_reg == start_cell_reg || len_reg == CNTW'(CELLS))
                begin
                    stored_len_next = len_reg;
                    robot_x_next    = goal_x_reg;
                    robot_y_next    = goal_y_reg;
                    out_set         = 1'b1;
                    state_next      = gap_pkg::S_IDLE;
                end
                else
                begin
                    cell_raddr = pcur_reg;
                    state_next = gap_pkg::S_PATH_CHECK;
                end
            end
            gap_pkg::S_PATH_CHECK:
            begin
                if (rd_mark_ok && rd_ns == gap_pkg::NODE_CLOSED)
                begin
                    pcur_next  = rd_parent;
                    path_we    = 1'b1;
                    path_waddr = len_reg[CB-1:0];
                    path_wdata = rd_parent;
                    len_next   = len_reg + 1'b1;
                    state_next = gap_pkg::S_PATH_RD;
                end
                else
                begin
                    stored_len_next = len_reg;
                    robot_x_next    = goal_x_reg;
                    robot_y_next    = goal_y_reg;
                    out_set         = 1'b1;
                    state_next      = gap_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = gap_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= gap_pkg::S_CLEAR;
            sweep_reg      <= '0;
            robot_x_reg    <= '0;
            robot_y_reg    <= '0;
            epoch_reg      <= '0;
            stored_len_reg <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sweep_reg      <= sweep_next;
            robot_x_reg    <= robot_x_next;
            robot_y_reg    <= robot_y_next;
            epoch_reg      <= epoch_next;
            stored_len_reg <= stored_len_next;
            done_reg       <= out_set;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg <= gap_pkg::MAP_SIZE_RESET;
            h_reg <= gap_pkg::MAP_SIZE_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == gap_pkg::CFG_MAP_WIDTH)
            begin
                w_reg <= cfg_wdata;
            end
            else
            begin
                h_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        goal_x_reg     <= goal_x_next;
        goal_y_reg     <= goal_y_next;
        start_cell_reg <= start_cell_next;
        cur_cell_reg   <= cur_cell_next;
        cur_g_reg      <= cur_g_next;
        dir_reg        <= dir_next;
        nb_cell_reg    <= nb_cell_next;
        nb_g_reg       <= nb_g_next;
        nb_f_reg       <= nb_f_next;
        len_reg        <= len_next;
        pcur_reg       <= pcur_next;
        if (out_set)
        begin
            status_reg  <= out_status;
            point_x_reg <= out_px;
            point_y_reg <= out_py;
        end
    end

    assign busy        = (state_reg != gap_pkg::S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign path_length = 11'(stored_len_reg);
    assign point_x     = point_x_reg;
    assign point_y     = point_y_reg;

    // a result transfer only ever follows the sequencer's return to idle
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result strobe while busy");

    // the sequencer leaves idle only on a command transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a command");

    // a search always runs under a nonzero mark, so loaded cells never match it
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gap_pkg::S_NB_CHECK || state_reg == gap_pkg::S_PATH_CHECK)
        |-> (epoch_reg != '0))
        else $error("search running with zero mark");

endmodule

@@ dv/tb_grid_astar_path_planner_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for grid_astar_path_planner_top: a queue-fed command driver,
// a result monitor and a built-in A* predictor of the planner's map, search and path store.
// Depends on gap_pkg and the planner RTL.
module tb_grid_astar_path_planner_top;

    localparam int GRID_W     = 32;
    localparam int GRID_N     = 1024;
    localparam int CYC_LIMIT  = 20000000;
    localparam int MODE_UNDEF = 3;    // no command uses this code
    localparam int KIND_UNDEF = 3;    // no cell kind uses this code

    typedef struct {
        logic [1:0] mode;
        logic [5:0] x;
        logic [5:0] y;
        logic [1:0] kind;
        logic [9:0] idx;
        bit         hold;   // wait for every result before this transfer
    } cmd_t;

    typedef struct {
        logic [2:0]  status;
        logic [10:0] len;
        logic [4:0]  px;
        logic [4:0]  py;
    } result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [5:0]  cfg_wdata = '0;
    logic [1:0]  mode = '0;
    logic [5:0]  pos_x = '0;
    logic [5:0]  pos_y = '0;
    logic [1:0]  cell_kind = '0;
    logic [9:0]  step_index = '0;
    logic        done;
    logic [2:0]  status;
    logic [10:0] path_length;
    logic [4:0]  point_x;
    logic [4:0]  point_y;

    grid_astar_path_planner_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .mode       (mode),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .cell_kind  (cell_kind),
        .step_index (step_index),
        .done       (done),
        .status     (status),
        .path_length(path_length),
        .point_x    (point_x),
        .point_y    (point_y)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: map registers, wall bits, robot, stored route
    // ------------------------------------------------------------------
    logic [5:0] width_reg  = gap_pkg::MAP_SIZE_RESET;
    logic [5:0] height_reg = gap_pkg::MAP_SIZE_RESET;
    bit         wall_bit [GRID_N];
    int         robot_col, robot_row;
    int         route_cell [GRID_N];
    int         route_len;

    // search scratch: open and closed lists (cell, parent, g, f)
    int ol_cell [GRID_N], ol_par [GRID_N], ol_g [GRID_N], ol_f [GRID_N];
    int cl_cell [GRID_N], cl_par [GRID_N];

    cmd_t    pending_cmds[$];
    result_t expected_results[$];
    cmd_t    cur_cmd;
    int      sender_idle_pct = 34;
    int      errors = 0;
    int      cycles = 0;

    function automatic int eff_dim(logic [5:0] v);
        return (v < GRID_W) ? int'(v) : GRID_W;
    endfunction

    // A* from the robot to (gx, gy); updates the route and robot on success
    function automatic logic [2:0] plan_route(int gx, int gy);
        int dxs [4] = '{-1, 1, 0, 0};
        int dys [4] = '{0, 0, -1, 1};
        int w, h, goal, strt, oc, cc, cur_c, cur_p, cur_g, cur_f;
        int cx, cy, nx, ny, c, j, k, best, nf, len;
        bit hit;
        w = eff_dim(width_reg);
        h = eff_dim(height_reg);
        if (gx >= w || gy >= h)
            return gap_pkg::ST_OUTSIDE;
        goal = gy * GRID_W + gx;
        if (wall_bit[goal])
            return gap_pkg::ST_GOAL_WALL;
        if (robot_col >= w || robot_row >= h)
            return gap_pkg::ST_NO_PATH;
        strt = robot_row * GRID_W + robot_col;
        oc = 0;
        cc = 0;
        cur_c = strt;
        cur_p = strt;
        cur_g = 0;
        forever
        begin
            cl_cell[cc] = cur_c;
            cl_par[cc]  = cur_p;
            cc++;
            cx = cur_c % GRID_W;
            cy = cur_c / GRID_W;
            // neighbors west, east, north, south; off-grid ones are blocked
            for (int d = 0; d < 4; d++)
            begin
                nx = cx + dxs[d];
                ny = cy + dys[d];
                if (nx < 0 || ny < 0 || nx >= w || ny >= h)
                    continue;
                c = ny * GRID_W + nx;
                if (wall_bit[c])
                    continue;
                hit = 0;
                for (k = 0; k < cc; k++)
                    if (cl_cell[k] == c)
                        hit = 1;
                if (hit)
                    continue;
                nf = cur_g + 1 + (nx > gx ? nx - gx : gx - nx) + (ny > gy ? ny - gy : gy - ny);
                for (j = 0; j < oc; j++)
                    if (ol_cell[j] == c)
                        break;
                if (j < oc)
                begin
                    // replace in place only on a strictly lower f
                    if (nf < ol_f[j])
                    begin
                        ol_par[j] = cur_c;
                        ol_g[j]   = cur_g + 1;
                        ol_f[j]   = nf;
                    end
                end
                else if (oc < GRID_N)
                begin
                    ol_cell[oc] = c;
                    ol_par[oc]  = cur_c;
                    ol_g[oc]    = cur_g + 1;
                    ol_f[oc]    = nf;
                    oc++;
                end
            end
            if (cur_c == goal)
                break;
            if (oc == 0)
                return gap_pkg::ST_NO_PATH;
            // first entry of least f, then swap-remove
            best = 0;
            for (int i = 0; i < oc; i++)
                if (ol_f[i] < ol_f[best])
                    best = i;
            cur_c = ol_cell[best];
            cur_p = ol_par[best];
            cur_g = ol_g[best];
            ol_cell[best] = ol_cell[oc-1];
            ol_par[best]  = ol_par[oc-1];
            ol_g[best]    = ol_g[oc-1];
            ol_f[best]    = ol_f[oc-1];
            oc--;
        end
        // walk parents from the goal back to the start
        len = 0;
        c = goal;
        route_cell[len++] = c;
        while (c != strt && len < GRID_N)
        begin
            k = -1;
            for (int i = 0; i < cc; i++)
                if (k < 0 && cl_cell[i] == c)
                    k = i;
            if (k < 0)
                break;
            c = cl_par[k];
            route_cell[len++] = c;
        end
        route_len = len;
        robot_col = gx;
        robot_row = gy;
        return gap_pkg::ST_OK;
    endfunction

    function automatic result_t predict_result(cmd_t cm);
        result_t r;
        int ci;
        r.status = gap_pkg::ST_OK;
        r.px = '0;
        r.py = '0;
        if (cm.mode == gap_pkg::MODE_LOAD)
        begin
            if (cm.x >= eff_dim(width_reg) || cm.y >= eff_dim(height_reg))
                r.status = gap_pkg::ST_OUTSIDE;
            else
            begin
                ci = int'(cm.y) * GRID_W + int'(cm.x);
                if (cm.kind == gap_pkg::KIND_FREE)
                    wall_bit[ci] = 0;
                else if (cm.kind == gap_pkg::KIND_WALL)
                    wall_bit[ci] = 1;
                else if (cm.kind == gap_pkg::KIND_ROBOT)
                begin
                    wall_bit[ci] = 0;
                    robot_col = cm.x;
                    robot_row = cm.y;
                end
            end
        end
        else if (cm.mode == gap_pkg::MODE_PLAN)
            r.status = plan_route(cm.x, cm.y);
        else if (cm.mode == gap_pkg::MODE_READ)
        begin
            if (cm.idx < route_len)
            begin
                r.px = 5'(route_cell[cm.idx] % GRID_W);
                r.py = 5'(route_cell[cm.idx] / GRID_W);
            end
            else
                r.status = gap_pkg::ST_BAD_INDEX;
        end
        else
            r.status = gap_pkg::ST_BAD_INDEX;
        r.len = 11'(route_len);
        return r;
    endfunction

    task automatic report(string msg);
        $display("ERROR @%0t: %s", $time, msg);
        errors++;
    endtask

    // ------------------------------------------------------------------
    // Driver: a transfer happens when start && !busy; start holds until then
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        bit fire;
        bit can_send;
        fire = rst_n && start && !busy;
        if (fire)
            expected_results.push_back(predict_result(cur_cmd));
        if (start && !fire)
        begin
            // keep holding the same command
        end
        else
        begin
            can_send = rst_n && pending_cmds.size() > 0 &&
                       $urandom_range(99) >= sender_idle_pct;
            if (can_send && pending_cmds[0].hold && expected_results.size() > 0)
                can_send = 0;
            if (can_send)
            begin
                cur_cmd = pending_cmds.pop_front();
                mode       <= cur_cmd.mode;
                pos_x      <= cur_cmd.x;
                pos_y      <= cur_cmd.y;
                cell_kind  <= cur_cmd.kind;
                step_index <= cur_cmd.idx;
                start      <= 1'b1;
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: one result per done pulse, checked against the oldest prediction
    always @(posedge clk)
    begin
        result_t e;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
                report("result with nothing predicted");
            else
            begin
                e = expected_results.pop_front();
                if (status !== e.status)
                    report($sformatf("status %0d, predicted %0d", status, e.status));
                if (path_length !== e.len)
                    report($sformatf("path_length %0d, predicted %0d", path_length, e.len));
                if (point_x !== e.px)
                    report($sformatf("point_x %0d, predicted %0d", point_x, e.px));
                if (point_y !== e.py)
                    report($sformatf("point_y %0d, predicted %0d", point_y, e.py));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYC_LIMIT)
        begin
            $display("grid_astar_path_planner_top test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_cmd(int m, int x, int y, int k = gap_pkg::KIND_FREE,
                            int idx = 0, bit hold = 0);
        cmd_t cm;
        cm.mode = 2'(m);
        cm.x    = 6'(x);
        cm.y    = 6'(y);
        cm.kind = 2'(k);
        cm.idx  = 10'(idx);
        cm.hold = hold;
        pending_cmds.push_back(cm);
    endtask

    task automatic wait_idle();
        while (pending_cmds.size() > 0 || expected_results.size() > 0 || start || busy)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // only written with nothing in flight; predictor follows the write
    task automatic set_map_size(int w, int h);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= gap_pkg::CFG_MAP_WIDTH;
        cfg_wdata <= 6'(w);
        @(posedge clk);
        cfg_index <= gap_pkg::CFG_MAP_HEIGHT;
        cfg_wdata <= 6'(h);
        @(posedge clk);
        cfg_we <= 1'b0;
        width_reg  = 6'(w);
        height_reg = 6'(h);
    endtask

    // mostly well-formed sequences: a few loads, robot, plan, reads; some noise
    task automatic run_random(int n_items);
        int w, h, cnt, nw, nr, gx, gy;
        w = eff_dim(width_reg);
        h = eff_dim(height_reg);
        cnt = 0;
        while (cnt < n_items)
        begin
            if ($urandom_range(99) < 20)
            begin
                push_cmd($urandom_range(3), $urandom_range(63), $urandom_range(63),
                         $urandom_range(3), $urandom_range(1023));
                cnt++;
                continue;
            end
            nw = $urandom_range(3);
            for (int i = 0; i < nw; i++)
                push_cmd(gap_pkg::MODE_LOAD, $urandom_range(w - 1), $urandom_range(h - 1),
                         $urandom_range(1) ? gap_pkg::KIND_WALL : gap_pkg::KIND_FREE);
            push_cmd(gap_pkg::MODE_LOAD, $urandom_range(w - 1), $urandom_range(h - 1),
                     gap_pkg::KIND_ROBOT, 0, $urandom_range(7) == 0);
            gx = $urandom_range(w - 1);
            gy = $urandom_range(h - 1);
            push_cmd(gap_pkg::MODE_PLAN, gx, gy);
            nr = $urandom_range(1, 3);
            for (int i = 0; i < nr; i++)
                push_cmd(gap_pkg::MODE_READ, 0, 0, gap_pkg::KIND_FREE,
                         $urandom_range(9) == 0 ? $urandom_range(1023) : $urandom_range(w + h));
            cnt += nw + nr + 2;
        end
    endtask

    initial
    begin
        foreach (wall_bit[i])
            wall_bit[i] = 0;
        robot_col = 0;
        robot_row = 0;
        route_len = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed part on the full 32 x 32 map, sender idles 34%
        set_map_size(32, 32);
        push_cmd(gap_pkg::MODE_READ, 0, 0, gap_pkg::KIND_FREE, 0);    // nothing stored yet
        push_cmd(gap_pkg::MODE_READ, 63, 63, gap_pkg::KIND_FREE, 1023);
        push_cmd(MODE_UNDEF, 7, 7, gap_pkg::KIND_WALL, 5);          // undefined mode
        push_cmd(gap_pkg::MODE_LOAD, 40, 5, gap_pkg::KIND_WALL);      // load outside, column
        push_cmd(gap_pkg::MODE_LOAD, 5, 63, gap_pkg::KIND_WALL);      // load outside, row
        push_cmd(gap_pkg::MODE_LOAD, 3, 3, KIND_UNDEF);               // kind three ignored
        push_cmd(gap_pkg::MODE_PLAN, 63, 63);                         // goal outside
        push_cmd(gap_pkg::MODE_PLAN, 32, 0);                          // goal just past the edge
        push_cmd(gap_pkg::MODE_LOAD, 4, 4, gap_pkg::KIND_WALL);
        push_cmd(gap_pkg::MODE_PLAN, 4, 4);                           // goal on wall
        push_cmd(gap_pkg::MODE_PLAN, 0, 0);                           // goal equals start
        push_cmd(gap_pkg::MODE_READ, 0, 0, gap_pkg::KIND_FREE, 0);
        push_cmd(gap_pkg::MODE_LOAD, 2, 0, gap_pkg::KIND_WALL);
        push_cmd(gap_pkg::MODE_LOAD, 2, 1, gap_pkg::KIND_WALL);
        push_cmd(gap_pkg::MODE_PLAN, 4, 1);                           // detour around the walls
        push_cmd(gap_pkg::MODE_READ, 0, 0, gap_pkg::KIND_FREE, 3);
        push_cmd(gap_pkg::MODE_LOAD, 31, 31, gap_pkg::KIND_WALL);
        push_cmd(gap_pkg::MODE_LOAD, 31, 31, gap_pkg::KIND_ROBOT);    // robot clears the wall
        push_cmd(gap_pkg::MODE_PLAN, 0, 31);                          // full row along the edge
        push_cmd(gap_pkg::MODE_READ, 0, 0, gap_pkg::KIND_FREE, 31);
        push_cmd(gap_pkg::MODE_READ, 0, 0, gap_pkg::KIND_FREE, 32);   // one past the end
        push_cmd(gap_pkg::MODE_LOAD, 0, 0, gap_pkg::KIND_ROBOT);
        push_cmd(gap_pkg::MODE_LOAD, 1, 0, gap_pkg::KIND_WALL);
        push_cmd(gap_pkg::MODE_LOAD, 0, 1, gap_pkg::KIND_WALL);
        push_cmd(gap_pkg::MODE_PLAN, 0, 5, gap_pkg::KIND_FREE, 0, 1); // boxed in: open list empties
        push_cmd(gap_pkg::MODE_READ, 0, 0, gap_pkg::KIND_FREE, 1);    // old route kept
        push_cmd(gap_pkg::MODE_LOAD, 20, 20, gap_pkg::KIND_ROBOT);

        // small map leaves the robot outside the grid in use
        set_map_size(8, 6);
        sender_idle_pct = 56;
        push_cmd(gap_pkg::MODE_PLAN, 1, 1);
        run_random(50);

        // single column and single row extremes, no sender idling from here
        set_map_size(1, 32);
        sender_idle_pct = 0;
        run_random(10);
        set_map_size(32, 1);
        run_random(10);
        set_map_size(5, 5);
        run_random(25);

        // oversized registers act as the full map
        set_map_size(63, 63);
        run_random(20);

        wait_idle();
        if (errors == 0)
            $display("grid_astar_path_planner_top test passed");
        else
            $display("grid_astar_path_planner_top test failed");
        $finish;
    end

endmodule

@@ filelist.f @@
src/gap_pkg.sv
src/gap_ram.sv
src/gap_open.sv
src/grid_astar_path_planner_top.sv
dv/tb_grid_astar_path_planner_top.sv
